>>> design/sib_pkg.sv
// shared types and constants for the sorted insert buffer
`default_nettype none
package sib_pkg;

	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EMIT = 2'b10
	} state_t;

endpackage
`default_nettype wire

>>> design/sib_if.sv
// request channels of the sorted insert buffer: item, result and capacity write
`default_nettype none
interface sib_item_if #(
	parameter int unsigned VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] new_value;

	modport source (output valid, output new_value, input ready);
	modport sink (input valid, input new_value, output ready);
endinterface

interface sib_result_if #(
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned IDX_W       = 4,
	parameter int unsigned CNT_W       = 5
);
	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [VALUE_WIDTH-1:0] entry_value;
	logic [IDX_W-1:0]       entry_index;
	logic [CNT_W-1:0]       entry_count;
	logic                   last_entry;

	modport source (
		output valid, output accepted, output entry_value, output entry_index,
		output entry_count, output last_entry, input ready
	);
	modport sink (
		input valid, input accepted, input entry_value, input entry_index,
		input entry_count, input last_entry, output ready
	);
endinterface

interface sib_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [sib_pkg::CAP_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/sib_cell.sv
// one storage cell of the insertion chain
`default_nettype none
module sib_cell #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   ins_en,
	input  wire logic                   beyond,
	input  wire logic [VALUE_WIDTH-1:0] new_value,
	input  wire logic                   left_take,
	input  wire logic [VALUE_WIDTH-1:0] left_value,
	output logic                        take,
	output logic [VALUE_WIDTH-1:0]      value
);

	logic [VALUE_WIDTH-1:0] value_q;

	// slot at or above the insertion point
	assign take  = beyond || ($signed(value_q) > $signed(new_value));
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ins_en && take) begin
			if (left_take) begin
				value_q <= left_value;
			end else begin
				value_q <= new_value;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/sorted_insert_buffer.sv
// top level of the sorted insert buffer
// flow: an item taken in idle moves the state to emit; results then leave through the output register
// throughput: one result a cycle while result.ready allows, from the single output register that
//   reads one cell per cycle; items are taken only in idle, and the cells are written as an item with room is taken
// reset: arst_n clears the count, capacity (to 16), state and output valid; cell
//   contents are undefined until written
`default_nettype none
module sorted_insert_buffer #(
	parameter int unsigned DEPTH       = 16,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sib_item_if.sink    item,
	sib_result_if.source result,
	sib_cfg_if.sink     cfg
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > sib_pkg::CAP_W) ? CNT_W : sib_pkg::CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	sib_pkg::state_t state_q;

	logic [sib_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0]          count_q;
	logic                      acc_q;
	logic [IDX_W-1:0]          idx_q;

	logic                   out_valid_q;
	logic                   out_acc_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [IDX_W-1:0]       out_index_q;
	logic [CNT_W-1:0]       out_count_q;
	logic                   out_last_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             has_room;
	logic             item_take;
	logic             ins_en;
	logic             load;
	logic             is_last;

	logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic                   cell_take  [DEPTH];

	assign cap_ext   = CMP_W'(cap_q);
	assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
	assign has_room  = CMP_W'(count_q) < eff_cap;
	assign item.ready = (state_q == sib_pkg::S_IDLE);
	assign item_take = item.valid && item.ready;
	assign ins_en    = item_take && has_room;
	assign cfg.ready = 1'b1;

	// insertion chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic beyond;
		assign beyond = CNT_W'(i) >= count_q;
		if (i == 0) begin : g_head
			sib_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
				.clk        (clk),
				.ins_en     (ins_en),
				.beyond     (beyond),
				.new_value  (item.new_value),
				.left_take  (1'b0),
				.left_value ('0),
				.take       (cell_take[i]),
				.value      (cell_value[i])
			);
		end else begin : g_body
			sib_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
				.clk        (clk),
				.ins_en     (ins_en),
				.beyond     (beyond),
				.new_value  (item.new_value),
				.left_take  (cell_take[i-1]),
				.left_value (cell_value[i-1]),
				.take       (cell_take[i]),
				.value      (cell_value[i])
			);
		end
	end

	assign load    = (state_q == sib_pkg::S_EMIT) && (!out_valid_q || result.ready);
	assign is_last = (count_q == '0) || (CNT_W'(idx_q) + CNT_W'(1) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sib_pkg::S_IDLE;
			cap_q       <= sib_pkg::CAP_RESET;
			count_q     <= '0;
			acc_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
			if (result.valid && result.ready && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sib_pkg::S_IDLE: begin
					if (item_take) begin
						acc_q   <= has_room;
						idx_q   <= '0;
						state_q <= sib_pkg::S_EMIT;
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				sib_pkg::S_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= sib_pkg::S_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= sib_pkg::S_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_acc_q   <= acc_q;
			out_value_q <= (count_q == '0) ? '0 : cell_value[idx_q];
			out_index_q <= idx_q;
			out_count_q <= count_q;
			out_last_q  <= is_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.accepted    = out_acc_q;
	assign result.entry_value = out_value_q;
	assign result.entry_index = out_index_q;
	assign result.entry_count = out_count_q;
	assign result.last_entry  = out_last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= DEPTH_C)
		else $error("held count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("count did not step on insert");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last_entry) |->
		(result.entry_count == '0 ||
		CNT_W'(result.entry_index) + CNT_W'(1) == result.entry_count))
		else $error("last entry at wrong index");

	a_no_take_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sib_pkg::S_EMIT) |-> !ins_en)
		else $error("insert during emission");
`endif

endmodule
`default_nettype wire

>>> tb/sv/sorted_insert_buffer_tb.sv
// testbench for the sorted insert buffer: random and directed inserts checked against a predictor
`timescale 1ns / 1ps
module sorted_insert_buffer_tb;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned VALUE_WIDTH = 16;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic                   accepted;
		logic [VALUE_WIDTH-1:0] entry_value;
		logic [3:0]             entry_index;
		logic [4:0]             entry_count;
		logic                   last_entry;
	} sorted_entry_t;

	logic clk = 1'b0;
	logic arst_n;

	sib_item_if #(.VALUE_WIDTH(VALUE_WIDTH)) item_ch ();
	sib_result_if #(.VALUE_WIDTH(VALUE_WIDTH)) res_ch ();
	sib_cfg_if cfg_ch ();

	sorted_insert_buffer #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic signed [VALUE_WIDTH-1:0] held_vals [DEPTH];
	int unsigned                   held_n;
	logic [sib_pkg::CAP_W-1:0]     capacity_model;

	logic [VALUE_WIDTH-1:0] pending_values [$];
	sorted_entry_t          expected_entries [$];

	int unsigned mismatch_count;
	bit          idling_on;
	bit          hold_go;
	logic        sink_hold_on;
	int unsigned send_idle_left;
	int unsigned sink_idle_left;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.new_value = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		sink_hold_on      = 1'b0;
		hold_go           = 1'b0;
		idling_on         = 1'b1;
		mismatch_count    = 0;
		send_idle_left    = 0;
		sink_idle_left    = 0;
		held_n            = 0;
		capacity_model    = sib_pkg::CAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
			input logic [VALUE_WIDTH-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	function automatic void insert_and_list(input logic signed [VALUE_WIDTH-1:0] v);
		int unsigned eff;
		int unsigned pos;
		int unsigned k;
		logic        acc;
		sorted_entry_t r;
		eff = (capacity_model > DEPTH) ? DEPTH : capacity_model;
		acc = 1'b0;
		if (held_n < eff) begin
			pos = 0;
			while (pos < held_n && held_vals[pos] <= v)
				pos++;
			for (k = held_n; k > pos; k--)
				held_vals[k] = held_vals[k-1];
			held_vals[pos] = v;
			held_n++;
			acc = 1'b1;
		end
		if (held_n == 0) begin
			r = '{accepted: acc, entry_value: '0, entry_index: '0, entry_count: '0,
				last_entry: 1'b1};
			expected_entries.push_back(r);
		end else begin
			for (k = 0; k < held_n; k++) begin
				r.accepted    = acc;
				r.entry_value = held_vals[k];
				r.entry_index = 4'(k);
				r.entry_count = 5'(held_n);
				r.last_entry  = (k + 1 == held_n);
				expected_entries.push_back(r);
			end
		end
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		unique case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// item request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (send_idle_left > 0) begin
				item_ch.valid <= 1'b0;
				send_idle_left--;
			end else if (pending_values.size() == 0) begin
				item_ch.valid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				item_ch.valid <= 1'b0;
				send_idle_left = $urandom_range(0, 7);
			end else begin
				item_ch.valid     <= 1'b1;
				item_ch.new_value <= pending_values.pop_front();
			end
		end
	end

	// result ready
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (sink_hold_on) begin
			res_ch.ready <= 1'b0;
		end else if (sink_idle_left > 0) begin
			res_ch.ready <= 1'b0;
			sink_idle_left--;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			res_ch.ready <= 1'b0;
			sink_idle_left = $urandom_range(0, 7);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// long receiver hold-off
	initial begin
		wait (hold_go);
		@(posedge clk);
		sink_hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold_on <= 1'b0;
	end

	always @(posedge clk) begin : result_monitor
		sorted_entry_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_entries.size() == 0) begin
					report_mismatch("result with nothing expected", res_ch.entry_value, '0);
				end else begin
					want = expected_entries.pop_front();
					if (res_ch.accepted !== want.accepted)
						report_mismatch("accepted", VALUE_WIDTH'(res_ch.accepted),
							VALUE_WIDTH'(want.accepted));
					if (res_ch.entry_value !== want.entry_value)
						report_mismatch("entry_value", res_ch.entry_value, want.entry_value);
					if (res_ch.entry_index !== want.entry_index)
						report_mismatch("entry_index", VALUE_WIDTH'(res_ch.entry_index),
							VALUE_WIDTH'(want.entry_index));
					if (res_ch.entry_count !== want.entry_count)
						report_mismatch("entry_count", VALUE_WIDTH'(res_ch.entry_count),
							VALUE_WIDTH'(want.entry_count));
					if (res_ch.last_entry !== want.last_entry)
						report_mismatch("last_entry", VALUE_WIDTH'(res_ch.last_entry),
							VALUE_WIDTH'(want.last_entry));
				end
			end
			if (item_ch.valid && item_ch.ready)
				insert_and_list(item_ch.new_value);
		end
	end

	task automatic write_capacity(input logic [sib_pkg::CAP_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		capacity_model = v;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_values.size() != 0 || item_ch.valid || expected_entries.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_phase(input logic [sib_pkg::CAP_W-1:0] cap, input int unsigned n);
		int unsigned i;
		write_capacity(cap);
		for (i = 0; i < n; i++)
			pending_values.push_back(pick_value());
	endtask

	initial begin
		wait (arst_n);
		@(negedge clk);

		// capacity zero: empty buffer, every request rejected
		write_capacity(5'd0);
		pending_values = '{16'h0000, 16'h8000, 16'h7fff};
		wait_drained();

		write_capacity(5'd1);
		pending_values = '{16'h8000, 16'h7fff};
		wait_drained();

		// equal values, extremes, full again
		write_capacity(5'd5);
		pending_values = '{16'h7fff, 16'h0000, 16'hffff, 16'h0000, 16'h1234};
		wait_drained();

		// capacity lowered below the count
		write_capacity(5'd2);
		pending_values = '{16'h8000, 16'h0001};
		wait_drained();

		// saturated capacity
		write_capacity(5'd31);
		pending_values = '{16'h8000, 16'h7fff};
		wait_drained();

		random_phase(5'd9, 40);
		hold_go = 1'b1;
		wait_drained();

		random_phase(5'd17, 40);
		wait_drained();

		random_phase(5'd16, 50);
		wait_drained();

		random_phase(5'd1, 20);
		wait_drained();

		idling_on = 1'b0;
		random_phase(5'd31, 30);
		wait_drained();

		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("sorted_insert_buffer test passed");
		else
			$display("sorted_insert_buffer test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("sorted_insert_buffer test failed");
		$finish;
	end

endmodule
